FILE: hw/rtl/sas_pkg.sv
package sas_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned SLOT_W = 4;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [2:0] {
        OP_PUSH16 = 3'd0,
        OP_PUSH32 = 3'd1,
        OP_POP16  = 3'd2,
        OP_POP32  = 3'd3,
        OP_PUSHA  = 3'd4,
        OP_PUSHAD = 3'd5,
        OP_POPA   = 3'd6,
        OP_POPAD  = 3'd7
    } t_opcode;

    typedef enum logic {
        CFG_STACK_IS_32BIT = 1'b0,
        CFG_STACK_BASE     = 1'b1
    } t_cfg_index;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } t_state;

    localparam logic [SLOT_W-1:0] SLOT_EXTERNAL = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_DISCARD  = 4'd9;
    localparam logic [IDX_W-1:0]  SLOT_ESP      = 3'd4;
    localparam logic [IDX_W-1:0]  IDX_LAST      = 3'd7;

    localparam logic [WORD_W-1:0] STEP_WORD   = 32'd2;
    localparam logic [WORD_W-1:0] STEP_DWORD  = 32'd4;
    localparam logic [WORD_W-1:0] BLOCK_WORD  = 32'd16;
    localparam logic [WORD_W-1:0] BLOCK_DWORD = 32'd32;
    localparam logic [WORD_W-1:0] MASK_16     = 32'h0000_FFFF;
    localparam logic [WORD_W-1:0] MASK_32     = 32'hFFFF_FFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } t_dp_stat;

    typedef struct packed {
        logic [WORD_W-1:0] mem_address;
        logic              is_write;
        logic              is_dword;
        logic [SLOT_W-1:0] reg_slot;
        logic [WORD_W-1:0] write_data;
        logic [WORD_W-1:0] new_esp;
        logic              last;
    } t_access;

endpackage

FILE: hw/rtl/sas_in_if.sv
interface sas_in_if;
    import sas_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic [WORD_W-1:0] esp_in;
    logic [WORD_W-1:0] push_data;

    modport source (output valid, output opcode, output esp_in, output push_data,
                    input ready);
    modport sink (input valid, input opcode, input esp_in, input push_data,
                  output ready);
endinterface

FILE: hw/rtl/sas_out_if.sv
interface sas_out_if;
    import sas_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] mem_address;
    logic              is_write;
    logic              is_dword;
    logic [SLOT_W-1:0] reg_slot;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] new_esp;
    logic              last;

    modport source (output valid, output mem_address, output is_write, output is_dword,
                    output reg_slot, output write_data, output new_esp, output last,
                    input ready);
    modport sink (input valid, input mem_address, input is_write, input is_dword,
                  input reg_slot, input write_data, input new_esp, input last,
                  output ready);
endinterface

FILE: hw/rtl/sas_cfg_if.sv
interface sas_cfg_if;
    import sas_pkg::*;

    logic              valid;
    logic              ready;
    logic              index;
    logic [WORD_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/sas_ctrl.sv
module sas_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  sas_pkg::t_dp_stat  i_stat,
    output sas_pkg::t_dp_cmd   o_cmd
);
    import sas_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BUSY;
                end
            end
            S_BUSY: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.advance = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An accepted operation always shows its first access on the next cycle.
    a_load_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("first access did not follow an accepted operation");

    // After the final access transfers, the block is ready for a new operation.
    a_last_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_stat.last) |=> (o_in_ready && !o_out_valid))
        else $error("block did not return to idle after the final access");

    // Input and output never both open in one cycle.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while an access is pending");
endmodule

FILE: hw/rtl/sas_datapath.sv
module sas_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sas_pkg::t_dp_cmd             i_cmd,
    output sas_pkg::t_dp_stat            o_stat,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [sas_pkg::WORD_W-1:0]   i_cfg_data,
    input  logic [2:0]                   i_opcode,
    input  logic [sas_pkg::WORD_W-1:0]   i_esp_in,
    input  logic [sas_pkg::WORD_W-1:0]   i_push_data,
    output sas_pkg::t_access             o_access
);
    import sas_pkg::*;

    logic              r_is32;
    logic [WORD_W-1:0] r_base;
    logic [WORD_W-1:0] r_ptr;
    logic [WORD_W-1:0] r_nesp;
    logic [WORD_W-1:0] r_data;
    logic              r_dw;
    logic              r_wr;
    logic              r_multi;
    logic [IDX_W-1:0]  r_idx;

    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] keep;
    logic              dw_in;
    logic [WORD_W-1:0] step_in;
    logic [WORD_W-1:0] block_in;
    logic [WORD_W-1:0] step_cur;
    logic [WORD_W-1:0] n_ptr;
    logic [WORD_W-1:0] n_nesp;
    logic [WORD_W-1:0] n_data;
    logic              n_wr;
    logic              n_multi;
    logic [IDX_W-1:0]  rev_idx;
    logic [SLOT_W-1:0] slot;
    logic              last;

    assign mask     = r_is32 ? MASK_32 : MASK_16;
    assign keep     = i_esp_in & ~mask;
    assign dw_in    = i_opcode[0];
    assign step_in  = dw_in ? STEP_DWORD : STEP_WORD;
    assign block_in = dw_in ? BLOCK_DWORD : BLOCK_WORD;
    assign step_cur = r_dw ? STEP_DWORD : STEP_WORD;

    // First access of the operation and the final pointer.
    always_comb begin
        n_ptr   = i_esp_in & mask;
        n_nesp  = i_esp_in;
        n_data  = '0;
        n_wr    = 1'b0;
        n_multi = 1'b0;
        case (t_opcode'(i_opcode))
            OP_PUSH16, OP_PUSH32: begin
                n_ptr  = (i_esp_in - step_in) & mask;
                n_nesp = ((i_esp_in - step_in) & mask) | keep;
                n_data = dw_in ? i_push_data : (i_push_data & MASK_16);
                n_wr   = 1'b1;
            end
            OP_POP16, OP_POP32: begin
                n_nesp = ((i_esp_in + step_in) & mask) | keep;
            end
            OP_PUSHA, OP_PUSHAD: begin
                n_ptr   = (i_esp_in - step_in) & mask;
                n_nesp  = ((i_esp_in - block_in) & mask) | keep;
                n_wr    = 1'b1;
                n_multi = 1'b1;
            end
            OP_POPA, OP_POPAD: begin
                n_nesp  = ((i_esp_in + block_in) & mask) | keep;
                n_multi = 1'b1;
            end
            default: begin
                n_multi = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is32 <= 1'b0;
            r_base <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_STACK_IS_32BIT: r_is32 <= i_cfg_data[0];
                CFG_STACK_BASE:     r_base <= i_cfg_data;
                default:            r_is32 <= r_is32;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multi <= 1'b0;
            r_idx   <= '0;
        end else if (i_cmd.load) begin
            r_multi <= n_multi;
            r_idx   <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Pushes walk down the stack, pops walk up.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ptr  <= n_ptr;
            r_nesp <= n_nesp;
            r_data <= n_data;
            r_dw   <= dw_in;
            r_wr   <= n_wr;
        end else if (i_cmd.advance) begin
            r_ptr <= r_wr ? ((r_ptr - step_cur) & mask) : ((r_ptr + step_cur) & mask);
        end
    end

    // Pusha stores slots in ascending order; popa restores them in descending
    // order and drops the stack-pointer slot.
    always_comb begin
        rev_idx = IDX_LAST - r_idx;
        if (!r_multi) begin
            slot = SLOT_EXTERNAL;
        end else if (r_wr) begin
            slot = {1'b0, r_idx};
        end else if (rev_idx == SLOT_ESP) begin
            slot = SLOT_DISCARD;
        end else begin
            slot = {1'b0, rev_idx};
        end
    end

    assign last = !r_multi || (r_idx == IDX_LAST);

    assign o_stat.last          = last;
    assign o_access.mem_address = r_base + r_ptr;
    assign o_access.is_write    = r_wr;
    assign o_access.is_dword    = r_dw;
    assign o_access.reg_slot    = slot;
    assign o_access.write_data  = r_data;
    assign o_access.new_esp     = r_nesp;
    assign o_access.last        = last;

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.advance && !r_multi) |-> o_stat.last)
        else $error("single access not flagged as final");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.advance && r_multi && (r_idx != IDX_LAST)) |=>
        (r_idx == $past(r_idx) + 1'b1))
        else $error("access index did not step");

    a_load_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_idx == '0))
        else $error("access index not cleared on a new operation");
endmodule

FILE: hw/rtl/stack_access_sequencer.sv
// Channel  Role    Carries
// i_in     sink    opcode, esp_in, push_data: one stack operation
// o_out    source  one memory access: address, direction, size, slot, data, new_esp, last
// i_cfg    sink    register write: index 0 stack_is_32bit, index 1 stack_base
//
// A single push or pop is accepted and then makes one access transfer.
// Pusha, pushad, popa and popad make eight accesses: the sequencer emits one access per
// cycle while the output is ready, from its access index counter and pointer register.
// A stalled output holds the current access; no new operation is accepted
// until the final access transfers. Configuration writes are always taken.
// Reset clears both configuration registers and returns the sequencer to idle.
module stack_access_sequencer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sas_in_if.sink    i_in,
    sas_out_if.source o_out,
    sas_cfg_if.sink   i_cfg
);
    import sas_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_access  access;

    assign i_cfg.ready = 1'b1;

    sas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sas_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_opcode    (i_in.opcode),
        .i_esp_in    (i_in.esp_in),
        .i_push_data (i_in.push_data),
        .o_access    (access)
    );

    assign o_out.mem_address = access.mem_address;
    assign o_out.is_write    = access.is_write;
    assign o_out.is_dword    = access.is_dword;
    assign o_out.reg_slot    = access.reg_slot;
    assign o_out.write_data  = access.write_data;
    assign o_out.new_esp     = access.new_esp;
    assign o_out.last        = access.last;
endmodule

FILE: verif/sas_access_checker.sv
module sas_access_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sas_in_if    i_op_ch,
    sas_out_if   i_acc_ch,
    sas_cfg_if   i_cfg_ch,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sas_pkg::*;

    logic              stack32;
    logic [WORD_W-1:0] base_addr;
    t_access           expected_accesses[$];
    t_access           oldest;
    int                err_count;

    function automatic void queue_access(input logic [WORD_W-1:0] ptr, input logic wr,
                                         input logic dword, input logic [SLOT_W-1:0] slot,
                                         input logic [WORD_W-1:0] data,
                                         input logic [WORD_W-1:0] nesp, input logic fin);
        t_access acc;
        acc.mem_address = base_addr + ptr;
        acc.is_write    = wr;
        acc.is_dword    = dword;
        acc.reg_slot    = slot;
        acc.write_data  = data;
        acc.new_esp     = nesp;
        acc.last        = fin;
        expected_accesses.push_back(acc);
    endfunction

    task automatic predict_accesses(input t_opcode op, input logic [WORD_W-1:0] esp,
                                    input logic [WORD_W-1:0] data);
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] keep;
        logic [WORD_W-1:0] step;
        logic [WORD_W-1:0] ptr;
        logic [WORD_W-1:0] nesp;
        logic [SLOT_W-1:0] slot;
        logic              dword;
        mask  = stack32 ? MASK_32 : MASK_16;
        keep  = esp & ~mask;
        dword = op[0];
        step  = dword ? STEP_DWORD : STEP_WORD;
        case (op)
            OP_PUSH16, OP_PUSH32: begin
                ptr  = (esp - step) & mask;
                nesp = ptr | keep;
                queue_access(ptr, 1'b1, dword, SLOT_EXTERNAL,
                             dword ? data : {16'h0000, data[15:0]}, nesp, 1'b1);
            end
            OP_POP16, OP_POP32: begin
                ptr  = esp & mask;
                nesp = ((esp + step) & mask) | keep;
                queue_access(ptr, 1'b0, dword, SLOT_EXTERNAL, '0, nesp, 1'b1);
            end
            OP_PUSHA, OP_PUSHAD: begin
                // The register file supplies all eight values, the old pointer included.
                nesp = ((esp - (step << 3)) & mask) | keep;
                ptr  = esp;
                for (int i = 0; i < 8; i++) begin
                    ptr = (ptr - step) & mask;
                    queue_access(ptr, 1'b1, dword, SLOT_W'(i), '0, nesp, i == 7);
                end
            end
            default: begin
                nesp = ((esp + (step << 3)) & mask) | keep;
                ptr  = esp & mask;
                for (int i = 0; i < 8; i++) begin
                    slot = SLOT_W'(7 - i);
                    if (slot == SLOT_W'(SLOT_ESP)) begin
                        slot = SLOT_DISCARD;
                    end
                    queue_access(ptr, 1'b0, dword, slot, '0, nesp, i == 7);
                    ptr = (ptr + step) & mask;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_val,
                               input logic [WORD_W-1:0] act_val);
        if (exp_val !== act_val) begin
            err_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack32   = 1'b0;
            base_addr = '0;
            err_count = 0;
            expected_accesses.delete();
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                if (i_cfg_ch.index == CFG_STACK_IS_32BIT) begin
                    stack32 = i_cfg_ch.data[0];
                end else begin
                    base_addr = i_cfg_ch.data;
                end
            end
            if (i_op_ch.valid && i_op_ch.ready) begin
                predict_accesses(t_opcode'(i_op_ch.opcode), i_op_ch.esp_in, i_op_ch.push_data);
            end
            if (i_acc_ch.valid && i_acc_ch.ready) begin
                if (expected_accesses.size() == 0) begin
                    err_count++;
                    $display("%0t: access transfer: expected none, actual address %h slot %h",
                             $time, i_acc_ch.mem_address, i_acc_ch.reg_slot);
                end else begin
                    oldest = expected_accesses.pop_front();
                    check_field("mem_address", oldest.mem_address, i_acc_ch.mem_address);
                    check_field("is_write", oldest.is_write, i_acc_ch.is_write);
                    check_field("is_dword", oldest.is_dword, i_acc_ch.is_dword);
                    check_field("reg_slot", oldest.reg_slot, i_acc_ch.reg_slot);
                    check_field("write_data", oldest.write_data, i_acc_ch.write_data);
                    check_field("new_esp", oldest.new_esp, i_acc_ch.new_esp);
                    check_field("last", oldest.last, i_acc_ch.last);
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= expected_accesses.size();
    end

endmodule

FILE: verif/tb_stack_access_sequencer.sv
module tb_stack_access_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import sas_pkg::*;

    localparam int unsigned MAX_GAP  = 12;
    localparam int          SIDE_SRC = 0;
    localparam int          SIDE_SNK = 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned calm_left[2];
    int          errors;
    int          pending;

    sas_in_if  op_ch();
    sas_out_if acc_ch();
    sas_cfg_if cfg_ch();

    stack_access_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (acc_ch),
        .i_cfg   (cfg_ch)
    );

    sas_access_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_ch   (op_ch),
        .i_acc_ch  (acc_ch),
        .i_cfg_ch  (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("tb_stack_access_sequencer: done, errors");
        $finish;
    end

    // Now and then a side goes through a calm stretch with no idle cycles at all.
    function automatic int unsigned draw_gap(input int side);
        if (calm_left[side] == 0 && $urandom_range(0, 7) == 0) begin
            calm_left[side] = $urandom_range(6, 20);
        end
        if (calm_left[side] > 0) begin
            calm_left[side] = calm_left[side] - 1;
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Bias the pointer toward the 16-bit and 32-bit wrap points.
    function automatic logic [WORD_W-1:0] pick_esp();
        logic [WORD_W-1:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 3))
            0: return raw;
            1: return {raw[31:16], 16'($urandom_range(0, 40))};
            2: return {raw[31:16], 16'hFFFF - 16'($urandom_range(0, 40))};
            default: return raw[0] ? 32'($urandom_range(0, 40))
                                   : 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic send_op(input t_opcode op, input logic [WORD_W-1:0] esp,
                           input logic [WORD_W-1:0] data);
        int unsigned gap;
        gap = draw_gap(SIDE_SRC);
        if (gap > 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid     <= 1'b1;
        op_ch.opcode    <= op;
        op_ch.esp_in    <= esp;
        op_ch.push_data <= data;
        do @(posedge i_clk); while (!(op_ch.valid && op_ch.ready));
    endtask

    // The pending count is registered, so it is read only after waiting for a clock edge.
    task automatic wait_idle();
        op_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic configure(input logic is32, input logic [WORD_W-1:0] base);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_STACK_IS_32BIT;
        cfg_ch.data  <= {31'b0, is32};
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.index <= CFG_STACK_BASE;
        cfg_ch.data  <= base;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int unsigned stall;
        acc_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_gap(SIDE_SNK);
            if (stall > 0) begin
                acc_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            acc_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(acc_ch.valid && acc_ch.ready));
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        op_ch.valid     <= 1'b0;
        op_ch.opcode    <= OP_PUSH16;
        op_ch.esp_in    <= '0;
        op_ch.push_data <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_STACK_IS_32BIT;
        cfg_ch.data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 16-bit stack at base zero, as left by reset.
        send_op(OP_PUSH16, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(OP_PUSH32, 32'hFFFF_0002, 32'h0000_0000);
        send_op(OP_PUSH32, 32'h1234_5678, 32'hFFFF_FFFF);
        send_op(OP_POP16, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_POP32, 32'hABCD_FFFE, 32'h0000_0000);
        send_op(OP_PUSHA, 32'hFFFF_0004, 32'h5A5A_5A5A);
        send_op(OP_PUSHAD, 32'h0000_0010, 32'h0000_0000);
        send_op(OP_POPA, 32'h0000_FFF8, 32'hFFFF_FFFF);
        send_op(OP_POPAD, 32'hFFFF_FFF0, 32'h0000_0000);

        // Full 32-bit pointer with a base that makes every address wrap except at pointer zero.
        wait_idle();
        configure(1'b1, 32'hFFFF_FFFF);
        send_op(OP_PUSH16, 32'h0000_0000, 32'h0000_FFFF);
        send_op(OP_PUSHAD, 32'h0000_0008, 32'h0000_0000);
        send_op(OP_POPAD, 32'hFFFF_FFF8, 32'hFFFF_FFFF);
        send_op(OP_POP32, 32'hFFFF_FFFE, 32'h0000_0000);
        send_op(OP_PUSHA, 32'h0000_0000, 32'hFFFF_FFFF);
        send_op(OP_POPA, 32'hFFFF_FFFF, 32'h0000_0000);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: configure(1'b0, 32'hFFFF_FFF0);
                    2: configure(1'b1, $urandom());
                    3: configure(1'b0, $urandom());
                    default: configure(1'b0, 32'h0000_0000);
                endcase
            end
            repeat (20) begin
                send_op(t_opcode'(3'($urandom_range(0, 7))), pick_esp(), $urandom());
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_stack_access_sequencer: done, clean");
        end else begin
            $display("tb_stack_access_sequencer: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sas_pkg.sv
hw/rtl/sas_in_if.sv
hw/rtl/sas_out_if.sv
hw/rtl/sas_cfg_if.sv
hw/rtl/sas_ctrl.sv
hw/rtl/sas_datapath.sv
hw/rtl/stack_access_sequencer.sv
verif/sas_access_checker.sv
verif/tb_stack_access_sequencer.sv
